// ===== hw/rtl/i2cms_pkg.sv =====
package i2cms_pkg;

  localparam int unsigned DLY_W   = 10;
  localparam int unsigned POLL_W  = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BCNT_W  = 4;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = DLY_W;

  localparam logic [DLY_W-1:0]  PHASE_DELAY_RST = DLY_W'(10);
  localparam logic [POLL_W-1:0] ACK_POLL_RST    = POLL_W'(20);
  localparam logic [BCNT_W-1:0] BITS_PER_BYTE   = BCNT_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_DELAY = 1'b0,
    CFG_ACK_POLL    = 1'b1
  } cfg_idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_START     = 3'd0,
    OP_STOP      = 3'd1,
    OP_WRITE     = 3'd2,
    OP_READ_ACK  = 3'd3,
    OP_READ_NACK = 3'd4
  } opcode_t;

  typedef enum logic [16:0] {
    PH_IDLE     = 17'b00000000000000001,
    PH_ST_A     = 17'b00000000000000010,
    PH_ST_B     = 17'b00000000000000100,
    PH_SP_A     = 17'b00000000000001000,
    PH_SP_B     = 17'b00000000000010000,
    PH_WB_SETUP = 17'b00000000000100000,
    PH_WB_HIGH  = 17'b00000000001000000,
    PH_WB_LOW   = 17'b00000000010000000,
    PH_WA_POLL  = 17'b00000000100000000,
    PH_WA_HOLD  = 17'b00000001000000000,
    PH_WA_LOW   = 17'b00000010000000000,
    PH_RB_SETUP = 17'b00000100000000000,
    PH_RB_HIGH  = 17'b00001000000000000,
    PH_RB_LOW   = 17'b00010000000000000,
    PH_AK_SETUP = 17'b00100000000000000,
    PH_AK_HIGH  = 17'b01000000000000000,
    PH_AK_LOW   = 17'b10000000000000000
  } phase_t;

  typedef struct packed {
    logic              tick;
    logic              sda_in;
    logic              cmd_valid;
    logic [OP_W-1:0]   opcode;
    logic [BYTE_W-1:0] tx_byte;
  } item_t;

  typedef struct packed {
    logic              scl_out;
    logic              sda_out;
    logic              ready_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_error;
  } result_t;

  typedef struct packed {
    logic [DLY_W-1:0]  phase_delay_ticks;
    logic [POLL_W-1:0] ack_poll_limit;
  } cfg_t;

endpackage

// ===== hw/rtl/i2c_master_byte_sequencer.sv =====
// I2C master byte sequencer, pin-level.
// Input channel (in_valid/in_ready): one transaction per clock of the bus
// engine, carrying the time tick, sampled SDA and an optional command
// (start, stop, write byte with ACK poll, read byte then ACK or NACK).
// Result channel (out_valid/out_ready): exactly one transaction per input
// transaction, in order, giving SCL/SDA drive levels, ready, a done pulse,
// the last received byte and the ack error flag.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 sets the
// ticks per delay phase, index 1 the ACK poll limit. Write only while idle.
// An accepted input passes through the input register, then the result
// register, before its result appears on the out_ ports. Throughput: one
// transaction per cycle while the result channel does not stall, one sequencer step each.
// When out_ready is low the result register holds, the input register
// fills, and in_ready drops until the result is taken; nothing is lost.
// Reset (rst_n low, synchronous): sequencer idle, SCL/SDA released high,
// rx byte and error cleared, delay 10 ticks, poll limit 20; both
// pipeline registers empty.
module i2c_master_byte_sequencer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_tick,
  input  logic                                in_sda_in,
  input  logic                                in_cmd_valid,
  input  logic [i2cms_pkg::OP_W-1:0]          in_opcode,
  input  logic [i2cms_pkg::BYTE_W-1:0]        in_tx_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_scl_out,
  output logic                                out_sda_out,
  output logic                                out_ready_res,
  output logic                                out_done_res,
  output logic [i2cms_pkg::BYTE_W-1:0]        out_rx_byte,
  output logic                                out_ack_error,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [i2cms_pkg::CFG_DATA_W-1:0]    cfg_data
);

  i2cms_pkg::item_t   in_item;
  i2cms_pkg::item_t   item;
  i2cms_pkg::result_t res;
  i2cms_pkg::result_t res_r;
  i2cms_pkg::cfg_t    cfg_r;
  logic               item_valid;
  logic               step;
  logic               out_valid_r;
  logic               out_valid_nxt;

  assign in_item.tick      = in_tick;
  assign in_item.sda_in    = in_sda_in;
  assign in_item.cmd_valid = in_cmd_valid;
  assign in_item.opcode    = in_opcode;
  assign in_item.tx_byte   = in_tx_byte;

  assign step = item_valid && (!out_valid_r || out_ready);

  i2cms_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  i2cms_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item),
    .cfg   (cfg_r),
    .res   (res)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_delay_ticks <= i2cms_pkg::PHASE_DELAY_RST;
      cfg_r.ack_poll_limit    <= i2cms_pkg::ACK_POLL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        i2cms_pkg::CFG_PHASE_DELAY: cfg_r.phase_delay_ticks <= cfg_data;
        i2cms_pkg::CFG_ACK_POLL:
          cfg_r.ack_poll_limit <= cfg_data[i2cms_pkg::POLL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_nxt = step ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl_out   = res_r.scl_out;
  assign out_sda_out   = res_r.sda_out;
  assign out_ready_res = res_r.ready_res;
  assign out_done_res  = res_r.done_res;
  assign out_rx_byte   = res_r.rx_byte;
  assign out_ack_error = res_r.ack_error;

endmodule

// ===== hw/rtl/i2cms_in_stage.sv =====
module i2cms_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  i2cms_pkg::item_t in_item,
  input  logic            take,
  output logic            item_valid,
  output i2cms_pkg::item_t item
);

  logic             valid_r;
  logic             valid_nxt;
  i2cms_pkg::item_t item_r;

  assign in_ready   = !valid_r || take;
  assign valid_nxt  = in_ready ? in_valid : valid_r;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== hw/rtl/i2cms_seq.sv =====
module i2cms_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  i2cms_pkg::item_t   item,
  input  i2cms_pkg::cfg_t    cfg,
  output i2cms_pkg::result_t res
);

  i2cms_pkg::phase_t                  phase_r, phase_nxt;
  logic [i2cms_pkg::BCNT_W-1:0]       bit_cnt_r, bit_cnt_nxt, bit_inc;
  logic [i2cms_pkg::DLY_W-1:0]        dly_r, dly_nxt, dly_dec;
  logic [i2cms_pkg::POLL_W-1:0]       poll_r, poll_nxt;
  logic [i2cms_pkg::BYTE_W-1:0]       shift_r, shift_nxt;
  logic [i2cms_pkg::BYTE_W-1:0]       rx_hold_r, rx_hold_nxt;
  logic                               scl_r, scl_nxt;
  logic                               sda_r, sda_nxt;
  logic                               err_r, err_nxt;
  logic                               nack_r, nack_nxt;
  logic                               dly_end;
  logic                               done;

  assign dly_end = item.tick && (dly_r <= i2cms_pkg::DLY_W'(1));
  assign dly_dec = !item.tick ? dly_r :
                   (dly_end ? '0 : dly_r - i2cms_pkg::DLY_W'(1));
  assign bit_inc = bit_cnt_r + i2cms_pkg::BCNT_W'(1);

  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    dly_nxt     = dly_r;
    poll_nxt    = poll_r;
    shift_nxt   = shift_r;
    rx_hold_nxt = rx_hold_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    err_nxt     = err_r;
    nack_nxt    = nack_r;
    done        = 1'b0;

    unique case (phase_r)
      i2cms_pkg::PH_IDLE: begin
        if (item.cmd_valid) begin
          unique case (item.opcode)
            i2cms_pkg::OP_START: begin
              sda_nxt   = 1'b1;
              scl_nxt   = 1'b1;
              phase_nxt = i2cms_pkg::PH_ST_A;
              dly_nxt   = cfg.phase_delay_ticks;
            end
            i2cms_pkg::OP_STOP: begin
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b0;
              phase_nxt = i2cms_pkg::PH_SP_A;
              dly_nxt   = cfg.phase_delay_ticks;
            end
            i2cms_pkg::OP_WRITE: begin
              scl_nxt     = 1'b0;
              sda_nxt     = item.tx_byte[i2cms_pkg::BYTE_W-1];
              shift_nxt   = {item.tx_byte[i2cms_pkg::BYTE_W-2:0], 1'b0};
              bit_cnt_nxt = '0;
              phase_nxt   = i2cms_pkg::PH_WB_SETUP;
              dly_nxt     = cfg.phase_delay_ticks;
            end
            i2cms_pkg::OP_READ_ACK, i2cms_pkg::OP_READ_NACK: begin
              nack_nxt    = (item.opcode == i2cms_pkg::OP_READ_NACK);
              sda_nxt     = 1'b1;
              shift_nxt   = '0;
              bit_cnt_nxt = '0;
              phase_nxt   = i2cms_pkg::PH_RB_SETUP;
              dly_nxt     = cfg.phase_delay_ticks;
            end
            default: begin
            end
          endcase
        end
      end
      i2cms_pkg::PH_ST_A: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          sda_nxt   = 1'b0;
          phase_nxt = i2cms_pkg::PH_ST_B;
          dly_nxt   = cfg.phase_delay_ticks;
        end
      end
      i2cms_pkg::PH_SP_A: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          sda_nxt   = 1'b1;
          phase_nxt = i2cms_pkg::PH_SP_B;
          dly_nxt   = cfg.phase_delay_ticks;
        end
      end
      i2cms_pkg::PH_ST_B, i2cms_pkg::PH_SP_B, i2cms_pkg::PH_AK_LOW: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          phase_nxt = i2cms_pkg::PH_IDLE;
          done      = 1'b1;
        end
      end
      i2cms_pkg::PH_WB_SETUP: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          scl_nxt   = 1'b1;
          phase_nxt = i2cms_pkg::PH_WB_HIGH;
          dly_nxt   = cfg.phase_delay_ticks;
        end
      end
      i2cms_pkg::PH_WB_HIGH: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          scl_nxt   = 1'b0;
          phase_nxt = i2cms_pkg::PH_WB_LOW;
          dly_nxt   = cfg.phase_delay_ticks;
        end
      end
      i2cms_pkg::PH_WB_LOW: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          bit_cnt_nxt = bit_inc;
          if (bit_inc < i2cms_pkg::BITS_PER_BYTE) begin
            sda_nxt   = shift_r[i2cms_pkg::BYTE_W-1];
            shift_nxt = {shift_r[i2cms_pkg::BYTE_W-2:0], 1'b0};
            phase_nxt = i2cms_pkg::PH_WB_SETUP;
            dly_nxt   = cfg.phase_delay_ticks;
          end else begin
            sda_nxt   = 1'b1;
            scl_nxt   = 1'b1;
            poll_nxt  = cfg.ack_poll_limit;
            phase_nxt = i2cms_pkg::PH_WA_POLL;
          end
        end
      end
      i2cms_pkg::PH_WA_POLL: begin
        if (item.tick) begin
          priority if (!item.sda_in) begin
            phase_nxt = i2cms_pkg::PH_WA_HOLD;
            dly_nxt   = cfg.phase_delay_ticks;
          end else if (poll_r <= i2cms_pkg::POLL_W'(1)) begin
            poll_nxt  = '0;
            err_nxt   = 1'b1;
            phase_nxt = i2cms_pkg::PH_IDLE;
            done      = 1'b1;
          end else begin
            poll_nxt = poll_r - i2cms_pkg::POLL_W'(1);
          end
        end
      end
      i2cms_pkg::PH_WA_HOLD: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          scl_nxt   = 1'b0;
          phase_nxt = i2cms_pkg::PH_WA_LOW;
          dly_nxt   = cfg.phase_delay_ticks;
        end
      end
      i2cms_pkg::PH_WA_LOW: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          err_nxt   = 1'b0;
          phase_nxt = i2cms_pkg::PH_IDLE;
          done      = 1'b1;
        end
      end
      i2cms_pkg::PH_RB_SETUP: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          scl_nxt   = 1'b1;
          phase_nxt = i2cms_pkg::PH_RB_HIGH;
          dly_nxt   = cfg.phase_delay_ticks;
        end
      end
      i2cms_pkg::PH_RB_HIGH: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          shift_nxt = {shift_r[i2cms_pkg::BYTE_W-2:0], item.sda_in};
          scl_nxt   = 1'b0;
          phase_nxt = i2cms_pkg::PH_RB_LOW;
          dly_nxt   = cfg.phase_delay_ticks;
        end
      end
      i2cms_pkg::PH_RB_LOW: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          bit_cnt_nxt = bit_inc;
          if (bit_inc < i2cms_pkg::BITS_PER_BYTE) begin
            phase_nxt = i2cms_pkg::PH_RB_SETUP;
          end else begin
            rx_hold_nxt = shift_r;
            sda_nxt     = nack_r;
            phase_nxt   = i2cms_pkg::PH_AK_SETUP;
          end
          dly_nxt = cfg.phase_delay_ticks;
        end
      end
      i2cms_pkg::PH_AK_SETUP: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          scl_nxt   = 1'b1;
          phase_nxt = i2cms_pkg::PH_AK_HIGH;
          dly_nxt   = cfg.phase_delay_ticks;
        end
      end
      i2cms_pkg::PH_AK_HIGH: begin
        dly_nxt = dly_dec;
        if (dly_end) begin
          scl_nxt   = 1'b0;
          phase_nxt = i2cms_pkg::PH_AK_LOW;
          dly_nxt   = cfg.phase_delay_ticks;
        end
      end
      default: begin
        phase_nxt = i2cms_pkg::PH_IDLE;
      end
    endcase
  end

  assign res.scl_out   = scl_nxt;
  assign res.sda_out   = sda_nxt;
  assign res.ready_res = (phase_nxt == i2cms_pkg::PH_IDLE);
  assign res.done_res  = done;
  assign res.rx_byte   = rx_hold_nxt;
  assign res.ack_error = err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= i2cms_pkg::PH_IDLE;
      bit_cnt_r <= '0;
      dly_r     <= '0;
      poll_r    <= '0;
      shift_r   <= '0;
      rx_hold_r <= '0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      err_r     <= 1'b0;
      nack_r    <= 1'b0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      dly_r     <= dly_nxt;
      poll_r    <= poll_nxt;
      shift_r   <= shift_nxt;
      rx_hold_r <= rx_hold_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      err_r     <= err_nxt;
      nack_r    <= nack_nxt;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int STALL_LIMIT  = 5000;
  localparam int TOTAL_ITEMS  = 800;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_REPORTS  = 10;
  localparam logic [i2cms_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [i2cms_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef enum int {ACK_FAST, ACK_SLOW, ACK_NEVER} ack_plan_t;

  class i2c_line_scoreboard;
    logic [i2cms_pkg::DLY_W-1:0]  delay_ticks;
    logic [i2cms_pkg::POLL_W-1:0] poll_limit;
    i2cms_pkg::phase_t            ph;
    logic [i2cms_pkg::BCNT_W-1:0] bit_cnt;
    logic [i2cms_pkg::DLY_W-1:0]  delay_cnt;
    logic [i2cms_pkg::POLL_W-1:0] poll_cnt;
    logic [i2cms_pkg::BYTE_W-1:0] shifter;
    logic [i2cms_pkg::BYTE_W-1:0] rx_hold;
    logic                         scl;
    logic                         sda;
    logic                         err;
    logic                         nack;
    i2cms_pkg::result_t           levels_due[$];
    int                           op_seen[1 << i2cms_pkg::OP_W];
    int                           done_cnt;
    int                           timeout_cnt;
    int                           mismatch_cnt;

    function new();
      delay_ticks  = i2cms_pkg::PHASE_DELAY_RST;
      poll_limit   = i2cms_pkg::ACK_POLL_RST;
      ph           = i2cms_pkg::PH_IDLE;
      bit_cnt      = '0;
      delay_cnt    = '0;
      poll_cnt     = '0;
      shifter      = '0;
      rx_hold      = '0;
      scl          = 1'b1;
      sda          = 1'b1;
      err          = 1'b0;
      nack         = 1'b0;
      done_cnt     = 0;
      timeout_cnt  = 0;
      mismatch_cnt = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function void write_reg(i2cms_pkg::cfg_idx_t idx,
                            logic [i2cms_pkg::CFG_DATA_W-1:0] val);
      if (idx == i2cms_pkg::CFG_PHASE_DELAY) delay_ticks = val[i2cms_pkg::DLY_W-1:0];
      else poll_limit = val[i2cms_pkg::POLL_W-1:0];
    endfunction

    function bit idle();
      return ph == i2cms_pkg::PH_IDLE;
    endfunction

    function void start_delay(i2cms_pkg::phase_t nxt);
      ph = nxt;
      delay_cnt = delay_ticks;
    endfunction

    // zero load behaves like one
    function bit delay_done(logic t);
      if (!t) return 1'b0;
      if (delay_cnt <= i2cms_pkg::DLY_W'(1)) begin
        delay_cnt = '0;
        return 1'b1;
      end
      delay_cnt = delay_cnt - i2cms_pkg::DLY_W'(1);
      return 1'b0;
    endfunction

    function void take_bus_item(i2cms_pkg::item_t it);
      i2cms_pkg::result_t want;
      logic               fin;
      fin = 1'b0;
      case (ph)
        i2cms_pkg::PH_IDLE: begin
          if (it.cmd_valid) begin
            op_seen[it.opcode]++;
            case (it.opcode)
              i2cms_pkg::OP_START: begin
                sda = 1'b1;
                scl = 1'b1;
                start_delay(i2cms_pkg::PH_ST_A);
              end
              i2cms_pkg::OP_STOP: begin
                scl = 1'b1;
                sda = 1'b0;
                start_delay(i2cms_pkg::PH_SP_A);
              end
              i2cms_pkg::OP_WRITE: begin
                scl = 1'b0;
                sda = it.tx_byte[i2cms_pkg::BYTE_W-1];
                shifter = {it.tx_byte[i2cms_pkg::BYTE_W-2:0], 1'b0};
                bit_cnt = '0;
                start_delay(i2cms_pkg::PH_WB_SETUP);
              end
              i2cms_pkg::OP_READ_ACK, i2cms_pkg::OP_READ_NACK: begin
                nack = (it.opcode == i2cms_pkg::OP_READ_NACK);
                sda = 1'b1;
                shifter = '0;
                bit_cnt = '0;
                start_delay(i2cms_pkg::PH_RB_SETUP);
              end
              default: ;
            endcase
          end
        end
        i2cms_pkg::PH_ST_A: if (delay_done(it.tick)) begin
          sda = 1'b0;
          start_delay(i2cms_pkg::PH_ST_B);
        end
        i2cms_pkg::PH_SP_A: if (delay_done(it.tick)) begin
          sda = 1'b1;
          start_delay(i2cms_pkg::PH_SP_B);
        end
        i2cms_pkg::PH_ST_B, i2cms_pkg::PH_SP_B: if (delay_done(it.tick)) begin
          ph = i2cms_pkg::PH_IDLE;
          fin = 1'b1;
        end
        i2cms_pkg::PH_WB_SETUP: if (delay_done(it.tick)) begin
          scl = 1'b1;
          start_delay(i2cms_pkg::PH_WB_HIGH);
        end
        i2cms_pkg::PH_WB_HIGH: if (delay_done(it.tick)) begin
          scl = 1'b0;
          start_delay(i2cms_pkg::PH_WB_LOW);
        end
        i2cms_pkg::PH_WB_LOW: if (delay_done(it.tick)) begin
          bit_cnt = bit_cnt + i2cms_pkg::BCNT_W'(1);
          if (bit_cnt < i2cms_pkg::BITS_PER_BYTE) begin
            sda = shifter[i2cms_pkg::BYTE_W-1];
            shifter = {shifter[i2cms_pkg::BYTE_W-2:0], 1'b0};
            start_delay(i2cms_pkg::PH_WB_SETUP);
          end else begin
            sda = 1'b1;
            scl = 1'b1;
            poll_cnt = poll_limit;
            ph = i2cms_pkg::PH_WA_POLL;
          end
        end
        i2cms_pkg::PH_WA_POLL: begin
          if (it.tick) begin
            if (!it.sda_in) begin
              start_delay(i2cms_pkg::PH_WA_HOLD);
            end else if (poll_cnt <= i2cms_pkg::POLL_W'(1)) begin
              poll_cnt = '0;
              err = 1'b1;
              ph = i2cms_pkg::PH_IDLE;
              fin = 1'b1;
              timeout_cnt++;
            end else begin
              poll_cnt = poll_cnt - i2cms_pkg::POLL_W'(1);
            end
          end
        end
        i2cms_pkg::PH_WA_HOLD: if (delay_done(it.tick)) begin
          scl = 1'b0;
          start_delay(i2cms_pkg::PH_WA_LOW);
        end
        i2cms_pkg::PH_WA_LOW: if (delay_done(it.tick)) begin
          err = 1'b0;
          ph = i2cms_pkg::PH_IDLE;
          fin = 1'b1;
        end
        i2cms_pkg::PH_RB_SETUP: if (delay_done(it.tick)) begin
          scl = 1'b1;
          start_delay(i2cms_pkg::PH_RB_HIGH);
        end
        i2cms_pkg::PH_RB_HIGH: if (delay_done(it.tick)) begin
          shifter = {shifter[i2cms_pkg::BYTE_W-2:0], it.sda_in};
          scl = 1'b0;
          start_delay(i2cms_pkg::PH_RB_LOW);
        end
        i2cms_pkg::PH_RB_LOW: if (delay_done(it.tick)) begin
          bit_cnt = bit_cnt + i2cms_pkg::BCNT_W'(1);
          if (bit_cnt < i2cms_pkg::BITS_PER_BYTE) begin
            start_delay(i2cms_pkg::PH_RB_SETUP);
          end else begin
            rx_hold = shifter;
            sda = nack;
            start_delay(i2cms_pkg::PH_AK_SETUP);
          end
        end
        i2cms_pkg::PH_AK_SETUP: if (delay_done(it.tick)) begin
          scl = 1'b1;
          start_delay(i2cms_pkg::PH_AK_HIGH);
        end
        i2cms_pkg::PH_AK_HIGH: if (delay_done(it.tick)) begin
          scl = 1'b0;
          start_delay(i2cms_pkg::PH_AK_LOW);
        end
        i2cms_pkg::PH_AK_LOW: if (delay_done(it.tick)) begin
          ph = i2cms_pkg::PH_IDLE;
          fin = 1'b1;
        end
        default: ph = i2cms_pkg::PH_IDLE;
      endcase
      if (fin) done_cnt++;
      want.scl_out   = scl;
      want.sda_out   = sda;
      want.ready_res = (ph == i2cms_pkg::PH_IDLE);
      want.done_res  = fin;
      want.rx_byte   = rx_hold;
      want.ack_error = err;
      levels_due.push_back(want);
    endfunction

    function void check_line_levels(i2cms_pkg::result_t got);
      i2cms_pkg::result_t want;
      if (levels_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result transaction: scl=%b sda=%b rdy=%b done=%b rx=%02h err=%b",
                   got.scl_out, got.sda_out, got.ready_res, got.done_res, got.rx_byte,
                   got.ack_error);
        return;
      end
      want = levels_due.pop_front();
      if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
          got.ready_res !== want.ready_res || got.done_res !== want.done_res ||
          got.rx_byte !== want.rx_byte || got.ack_error !== want.ack_error) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
          $display("mismatch at %0t: exp scl=%b sda=%b rdy=%b done=%b rx=%02h err=%b",
                   $realtime, want.scl_out, want.sda_out, want.ready_res, want.done_res,
                   want.rx_byte, want.ack_error);
          $display("                 got scl=%b sda=%b rdy=%b done=%b rx=%02h err=%b",
                   got.scl_out, got.sda_out, got.ready_res, got.done_res,
                   got.rx_byte, got.ack_error);
        end
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  logic                             in_tick;
  logic                             in_sda_in;
  logic                             in_cmd_valid;
  logic [i2cms_pkg::OP_W-1:0]       in_opcode;
  logic [i2cms_pkg::BYTE_W-1:0]     in_tx_byte;
  logic                             out_valid;
  logic                             out_ready;
  logic                             out_scl_out;
  logic                             out_sda_out;
  logic                             out_ready_res;
  logic                             out_done_res;
  logic [i2cms_pkg::BYTE_W-1:0]     out_rx_byte;
  logic                             out_ack_error;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [i2cms_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [i2cms_pkg::CFG_DATA_W-1:0] cfg_data;

  i2c_line_scoreboard sb = new();
  int                 tick_pct = 100;
  bit                 calm = 1'b0;
  int                 items_sent = 0;
  int                 cfg_writes = 0;
  int                 quiet_cycles = 0;
  int                 out_hold = 0;
  i2cms_pkg::result_t seen;

  i2c_master_byte_sequencer dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_tick      (in_tick),
    .in_sda_in    (in_sda_in),
    .in_cmd_valid (in_cmd_valid),
    .in_opcode    (in_opcode),
    .in_tx_byte   (in_tx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_scl_out  (out_scl_out),
    .out_sda_out  (out_sda_out),
    .out_ready_res(out_ready_res),
    .out_done_res (out_done_res),
    .out_rx_byte  (out_rx_byte),
    .out_ack_error(out_ack_error),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic ack_plan_t pick_plan();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return ACK_FAST;
    if (r < 85) return ACK_SLOW;
    return ACK_NEVER;
  endfunction

  function automatic i2cms_pkg::item_t busy_item(ack_plan_t plan);
    i2cms_pkg::item_t it;
    it.tick      = ($urandom_range(0, 99) < tick_pct);
    it.sda_in    = 1'($urandom_range(0, 1));
    it.cmd_valid = 1'($urandom_range(0, 1));
    it.opcode    = i2cms_pkg::OP_W'($urandom_range(0, OP_UNUSED_HI));
    it.tx_byte   = i2cms_pkg::BYTE_W'($urandom_range(0, 255));
    if (sb.ph == i2cms_pkg::PH_WA_POLL) begin
      case (plan)
        ACK_SLOW:  it.sda_in = ($urandom_range(0, 15) != 0);
        ACK_NEVER: it.sda_in = 1'b1;
        default:   ;
      endcase
    end
    return it;
  endfunction

  task automatic send_item(input i2cms_pkg::item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_tick      <= it.tick;
    in_sda_in    <= it.sda_in;
    in_cmd_valid <= it.cmd_valid;
    in_opcode    <= it.opcode;
    in_tx_byte   <= it.tx_byte;
    do @(posedge clk); while (!in_ready);
    sb.take_bus_item(it);
    items_sent++;
  endtask

  task automatic idle_items(input int n);
    i2cms_pkg::item_t it;
    repeat (n) begin
      it = busy_item(ACK_FAST);
      it.cmd_valid = ($urandom_range(0, 7) == 0);
      it.opcode = i2cms_pkg::OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      send_item(it);
    end
  endtask

  task automatic run_cmd(input logic [i2cms_pkg::OP_W-1:0] op,
                         input logic [i2cms_pkg::BYTE_W-1:0] tx,
                         input ack_plan_t plan);
    i2cms_pkg::item_t it;
    it = busy_item(plan);
    it.cmd_valid = 1'b1;
    it.opcode = op;
    it.tx_byte = tx;
    send_item(it);
    while (!sb.idle()) send_item(busy_item(plan));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.levels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [i2cms_pkg::DLY_W-1:0] dly,
                            input logic [i2cms_pkg::CFG_DATA_W-1:0] poll);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= i2cms_pkg::CFG_PHASE_DELAY;
    cfg_data  <= i2cms_pkg::CFG_DATA_W'(dly);
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(i2cms_pkg::CFG_PHASE_DELAY, i2cms_pkg::CFG_DATA_W'(dly));
    cfg_index <= i2cms_pkg::CFG_ACK_POLL;
    cfg_data  <= poll;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(i2cms_pkg::CFG_ACK_POLL, poll);
    cfg_valid <= 1'b0;
    cfg_writes += 2;
  endtask

  function automatic logic [i2cms_pkg::OP_W-1:0] data_op();
    case ($urandom_range(0, 2))
      0:       return i2cms_pkg::OP_WRITE;
      1:       return i2cms_pkg::OP_READ_ACK;
      default: return i2cms_pkg::OP_READ_NACK;
    endcase
  endfunction

  function automatic logic [i2cms_pkg::BYTE_W-1:0] rand_byte();
    return i2cms_pkg::BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic bus_transfer();
    int n;
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        idle_items($urandom_range(0, 3));
        run_cmd(i2cms_pkg::OP_W'($urandom_range(0, OP_UNUSED_HI)), rand_byte(), pick_plan());
      end
    end else begin
      idle_items($urandom_range(0, 3));
      run_cmd(i2cms_pkg::OP_START, rand_byte(), ACK_FAST);
      run_cmd(i2cms_pkg::OP_WRITE, rand_byte(), pick_plan());
      n = $urandom_range(1, 4);
      repeat (n) begin
        idle_items($urandom_range(0, 3));
        run_cmd(data_op(), rand_byte(), pick_plan());
      end
      if ($urandom_range(0, 9) != 0) run_cmd(i2cms_pkg::OP_STOP, rand_byte(), ACK_FAST);
    end
  endtask

  // one result transaction per accepted item
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen.scl_out   = out_scl_out;
      seen.sda_out   = out_sda_out;
      seen.ready_res = out_ready_res;
      seen.done_res  = out_done_res;
      seen.rx_byte   = out_rx_byte;
      seen.ack_error = out_ack_error;
      sb.check_line_levels(seen);
    end
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else begin
      out_hold = pick_gap();
      if (out_hold > 0) begin
        out_ready <= 1'b0;
        out_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int                               op;
    int                               unused_ops;
    int                               r;
    logic [i2cms_pkg::DLY_W-1:0]      dly;
    logic [i2cms_pkg::CFG_DATA_W-1:0] poll;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_tick      <= 1'b0;
    in_sda_in    <= 1'b1;
    in_cmd_valid <= 1'b0;
    in_opcode    <= i2cms_pkg::OP_START;
    in_tx_byte   <= '0;
    out_ready    <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= i2cms_pkg::CFG_PHASE_DELAY;
    cfg_data     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values first
    run_cmd(i2cms_pkg::OP_START, 8'h00, ACK_FAST);
    run_cmd(i2cms_pkg::OP_WRITE, 8'hFF, ACK_NEVER);
    for (op = int'(OP_UNUSED_LO); op <= int'(OP_UNUSED_HI); op++)
      run_cmd(i2cms_pkg::OP_W'(op), 8'h5A, ACK_FAST);
    run_cmd(i2cms_pkg::OP_STOP, 8'h00, ACK_FAST);

    set_config(i2cms_pkg::DLY_W'(1), i2cms_pkg::CFG_DATA_W'(1));
    run_cmd(i2cms_pkg::OP_WRITE, 8'h80, ACK_NEVER);
    run_cmd(i2cms_pkg::OP_WRITE, 8'h01, ACK_FAST);
    run_cmd(i2cms_pkg::OP_READ_ACK, 8'h00, ACK_FAST);
    tick_pct = 40;
    run_cmd(i2cms_pkg::OP_START, 8'hFF, ACK_FAST);
    run_cmd(i2cms_pkg::OP_STOP, 8'hFF, ACK_FAST);
    tick_pct = 100;
    set_config('0, '0);
    run_cmd(i2cms_pkg::OP_WRITE, 8'h7E, ACK_NEVER);
    run_cmd(i2cms_pkg::OP_WRITE, 8'hA5, ACK_SLOW);
    run_cmd(i2cms_pkg::OP_READ_NACK, 8'h00, ACK_FAST);
    run_cmd(i2cms_pkg::OP_STOP, 8'h00, ACK_FAST);
    // poll limit above 8 bits keeps only its low byte
    set_config(i2cms_pkg::DLY_W'(2), i2cms_pkg::CFG_DATA_W'(259));
    run_cmd(i2cms_pkg::OP_WRITE, 8'h3C, ACK_NEVER);

    while (items_sent < TOTAL_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r == 0) dly = '0;
      else if (r < 8) dly = i2cms_pkg::DLY_W'($urandom_range(1, 2));
      else dly = i2cms_pkg::DLY_W'($urandom_range(3, 5));
      if ($urandom_range(0, 9) == 0) poll = i2cms_pkg::CFG_DATA_W'($urandom_range(0, 1023));
      else poll = i2cms_pkg::CFG_DATA_W'($urandom_range(1, 30));
      case ($urandom_range(0, 3))
        0:       tick_pct = 40;
        1:       tick_pct = 100;
        default: tick_pct = 75;
      endcase
      calm = ($urandom_range(0, 3) == 0);
      set_config(dly, poll);
      bus_transfer();
    end

    calm = 1'b0;
    drain();
    unused_ops = 0;
    for (op = int'(OP_UNUSED_LO); op <= int'(OP_UNUSED_HI); op++)
      unused_ops += sb.op_seen[op];
    $display("Drove %0d bus items with %0d register writes: %0d start, %0d stop, %0d write,",
             items_sent, cfg_writes, sb.op_seen[i2cms_pkg::OP_START],
             sb.op_seen[i2cms_pkg::OP_STOP], sb.op_seen[i2cms_pkg::OP_WRITE]);
    $display("%0d read and %0d unused-opcode commands; %0d completed, %0d ack timeouts.",
             sb.op_seen[i2cms_pkg::OP_READ_ACK] + sb.op_seen[i2cms_pkg::OP_READ_NACK],
             unused_ops, sb.done_cnt, sb.timeout_cnt);
    if (sb.mismatch_cnt == 0 && sb.levels_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
